FILE: hdl/gmc_pkg.sv
// gmc_pkg: types, constants and helper functions of the global minimum cut block
// used by gmc_core and global_min_cut
`timescale 1ns / 1ps

package gmc_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = 6;
  localparam int ADDR_W       = 2 * VIDX_W;
  localparam int CUT_W        = 25;
  localparam logic [CUT_W-1:0] CUT_MAX = {CUT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PH_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_MERGE,
    ST_MERGE_END,
    ST_DONE
  } gmc_state_e;

  // edge beat and start request from the port side
  typedef struct packed {
    logic                   en;
    logic                   start;
    logic [ADDR_W-1:0]      addr;
    logic [WEIGHT_BITS-1:0] weight;
    logic [VCNT_W-1:0]      n;
  } gmc_load_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [CUT_W-1:0] cut;
  } gmc_stat_t;

  function automatic logic [CUT_W-1:0] sat_add(input logic [CUT_W-1:0] x,
                                               input logic [CUT_W-1:0] y);
    logic [CUT_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[CUT_W] ? CUT_MAX : s[CUT_W-1:0];
  endfunction

  // symmetric store keeps one entry per unordered pair
  function automatic logic [ADDR_W-1:0] pair_addr(input logic [VIDX_W-1:0] x,
                                                  input logic [VIDX_W-1:0] y);
    return (x < y) ? {x, y} : {y, x};
  endfunction

endpackage

FILE: hdl/global_min_cut.sv
// global_min_cut: top level with edge port, vertex count register and result register
// depends on gmc_pkg and gmc_core
//
// usage: edges arrive on the input channel (vertex_a, vertex_b, edge_weight,
// last_edge); each is written to the adjacency memory in the cycle it is
// accepted, one beat per cycle. a self loop is not stored. a beat with
// last_edge set stores its edge and then starts the cut computation; the
// input stays not ready until the result has been handed to the output
// register and the memory has been cleared.
// with n vertices in use the computation scans one memory row per step of a
// phase and reads one read port pair per merged entry.
// the result beat (min_cut) waits in an output register; a stalled receiver
// holds the block in its final state until the register frees up.
// after reset, and after every result, a clearing pass zeroes every memory
// entry; the input is not ready during it. vertex_count is written by
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle, as
// the block does not enforce this. it resets to 2 and is taken as 2 below 2 and as 32 above 32.
`timescale 1ns / 1ps

module global_min_cut import gmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [VCNT_W-1:0]      cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VIDX_W-1:0]      vertex_a_i,
  input  logic [VIDX_W-1:0]      vertex_b_i,
  input  logic [WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                   last_edge_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CUT_W-1:0]       min_cut_o
);

  logic [VCNT_W-1:0] vcount_q;
  logic [VCNT_W-1:0] n_eff;
  logic              out_valid_q;
  logic [CUT_W-1:0]  out_cut_q;
  logic              accept, out_free;
  gmc_load_t         load;
  gmc_stat_t         stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCNT_W'(2);
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (vcount_q < VCNT_W'(2)) n_eff = VCNT_W'(2);
    else if (vcount_q > VCNT_W'(MAX_VERTICES)) n_eff = VCNT_W'(MAX_VERTICES);
    else n_eff = vcount_q;
  end

  assign in_ready_o  = stat.idle;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign load.en     = accept && (vertex_a_i != vertex_b_i);
  assign load.start  = accept && last_edge_i;
  assign load.addr   = pair_addr(vertex_a_i, vertex_b_i);
  assign load.weight = edge_weight_i;
  assign load.n      = n_eff;

  gmc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .out_free_i (out_free),
    .stat_o     (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) out_cut_q <= stat.cut;
  end

  assign out_valid_o = out_valid_q;
  assign min_cut_o   = out_cut_q;

  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> out_free) else $error("result beat would overwrite a pending one");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_edge_i) |=> !in_ready_o) else $error("input ready during computation");

  a_done_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !in_ready_o) else $error("result beat while idle");

endmodule

FILE: hdl/gmc_adj_ram.sv
// gmc_adj_ram: adjacency memory, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module gmc_adj_ram #(
  parameter int AW = 10,
  parameter int DW = 25
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/gmc_core.sv
// gmc_core: phase sequencer, attachment scan, merge and clearing pass
// depends on gmc_pkg and gmc_adj_ram
`timescale 1ns / 1ps

module gmc_core import gmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gmc_load_t load_i,
  input  logic      out_free_i,
  output gmc_stat_t stat_o
);

  gmc_state_e state_q, state_d;

  logic [VCNT_W-1:0] n_q;
  logic [VIDX_W-1:0] phase_cnt_q;
  logic [VCNT_W-1:0] iss_q;
  logic              rd_v_q;
  logic [VIDX_W-1:0] rd_i_q;
  logic [MAX_VERTICES-1:0] inset_q, merged_q;
  logic              have_pick_q, have_prev_q, found_q;
  logic [VIDX_W-1:0] pick_q, last_q, prev_q, cand_q;
  logic [CUT_W-1:0]  cand_w_q, last_w_q, best_q;
  logic [CUT_W-1:0]  attach_q [MAX_VERTICES];
  logic [ADDR_W-1:0] clr_q;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [CUT_W-1:0]  wdata, rdata_a, rdata_b;
  logic              iss_more, alive, better, done;
  logic [VIDX_W-1:0] i_iss;
  logic [CUT_W-1:0]  nw;

  gmc_adj_ram #(.AW(ADDR_W), .DW(CUT_W)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign i_iss    = iss_q[VIDX_W-1:0];
  assign iss_more = iss_q < n_q;
  assign alive    = !merged_q[rd_i_q] && !inset_q[rd_i_q];
  assign nw       = have_pick_q ? sat_add(attach_q[rd_i_q], rdata_a) : attach_q[rd_i_q];
  assign better   = !found_q || (nw > cand_w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = pair_addr(prev_q, rd_i_q);
    wdata   = '0;
    raddr_a = pair_addr(pick_q, i_iss);
    raddr_b = pair_addr(last_q, i_iss);
    done    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == {ADDR_W{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        we    = load_i.en;
        waddr = load_i.addr;
        wdata = CUT_W'(load_i.weight);
        if (load_i.start) state_d = ST_PH_INIT;
      end
      ST_PH_INIT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (!iss_more && !rd_v_q) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (found_q) state_d = ST_SCAN;
        else if (have_prev_q) state_d = ST_MERGE;
        else state_d = ST_MERGE_END;
      end
      ST_MERGE: begin
        raddr_a = pair_addr(prev_q, i_iss);
        if (rd_v_q && !merged_q[rd_i_q] && rd_i_q != prev_q && rd_i_q != last_q) begin
          we    = 1'b1;
          wdata = sat_add(rdata_a, rdata_b);
        end
        if (!iss_more && !rd_v_q) state_d = ST_MERGE_END;
      end
      ST_MERGE_END: begin
        we    = have_prev_q;
        waddr = pair_addr(prev_q, last_q);
        if (phase_cnt_q == VIDX_W'(1)) state_d = ST_DONE;
        else state_d = ST_PH_INIT;
      end
      ST_DONE: begin
        if (out_free_i) begin
          done    = 1'b1;
          state_d = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= VCNT_W'(2);
      phase_cnt_q <= '0;
      iss_q       <= '0;
      rd_v_q      <= 1'b0;
      inset_q     <= '0;
      merged_q    <= '0;
      have_pick_q <= 1'b0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (state_q == ST_SCAN || state_q == ST_MERGE) begin
        rd_v_q <= iss_more;
        if (iss_more) iss_q <= iss_q + VCNT_W'(1);
      end else begin
        rd_v_q <= 1'b0;
        iss_q  <= '0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q    <= clr_q + ADDR_W'(1);
          merged_q <= '0;
        end
        ST_IDLE: begin
          if (load_i.start) begin
            n_q         <= load_i.n;
            phase_cnt_q <= VIDX_W'(load_i.n - VCNT_W'(1));
          end
        end
        ST_PH_INIT: begin
          inset_q     <= '0;
          have_pick_q <= 1'b0;
          have_prev_q <= 1'b0;
          found_q     <= 1'b0;
        end
        ST_SCAN: begin
          if (rd_v_q && alive && better) found_q <= 1'b1;
        end
        ST_SCAN_END: begin
          if (found_q) begin
            inset_q[cand_q] <= 1'b1;
            have_pick_q     <= 1'b1;
            if (have_pick_q) have_prev_q <= 1'b1;
            found_q         <= 1'b0;
          end
        end
        ST_MERGE_END: begin
          if (have_prev_q) merged_q[last_q] <= 1'b1;
          phase_cnt_q <= phase_cnt_q - VIDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN || state_q == ST_MERGE) rd_i_q <= i_iss;
    case (state_q)
      ST_IDLE: best_q <= CUT_MAX;
      ST_PH_INIT: begin
        for (int k = 0; k < MAX_VERTICES; k++) attach_q[k] <= '0;
      end
      ST_SCAN: begin
        if (rd_v_q && alive) begin
          attach_q[rd_i_q] <= nw;
          if (better) begin
            cand_q   <= rd_i_q;
            cand_w_q <= nw;
          end
        end
      end
      ST_SCAN_END: begin
        if (found_q) begin
          if (have_pick_q) prev_q <= last_q;
          last_q   <= cand_q;
          last_w_q <= cand_w_q;
          pick_q   <= cand_q;
        end else if (have_prev_q && last_w_q < best_q) begin
          best_q <= last_w_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = done;
  assign stat_o.cut  = best_q;

endmodule
